/* design/pid_line_follower_drive_core_defines.svh */
// ---------------------------------------------------------------------------
// pid_line_follower_drive_core_defines.svh
// Assertion macros used by the line follower drive RTL.
// ---------------------------------------------------------------------------
`ifndef PID_LINE_FOLLOWER_DRIVE_CORE_DEFINES_SVH
`define PID_LINE_FOLLOWER_DRIVE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define PLF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define PLF_ASSERT_NORST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLF_ASSERT(name, prop, msg)
`define PLF_ASSERT_NORST(name, prop, msg)
`endif

`endif

/* design/plf_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plf_pkg
// Types, register indexes and constants of the line follower drive core.
// ---------------------------------------------------------------------------
package plf_pkg;

  localparam int RawW   = 13;
  localparam int PosW   = 9;
  localparam int ErrW   = 11;
  localparam int SumW   = 24;
  localparam int GainW  = 16;
  localparam int LimW   = 10;
  localparam int BaseW  = 8;
  localparam int TurnW  = 11;
  localparam int SpeedW = 12;
  localparam int DutyW  = 8;

  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 16;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 32;

  // Position scaling: pos = floor(raw * 510 / 5000) - 255, with the divide
  // done as a multiply by 51 * ceil(2^27 / 500) and a shift by 27.
  localparam int ScaleMulW  = 24;
  localparam int ScaleShift = 27;
  localparam int ScaleProdW = RawW + ScaleMulW;
  localparam int ScaleQW    = 10;

  localparam logic [RawW-1:0]       RawFull   = RawW'(5000);
  localparam logic [ScaleMulW-1:0]  ScaleMul  = ScaleMulW'(13690236);
  localparam logic signed [ErrW-1:0] PosOffset = ErrW'(255);

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  localparam logic [DutyW-1:0] DutyMax = '1;

  typedef enum logic [CfgAddrW-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_BASE_SPEED = 3'd3,
    REG_TARGET_POS = 3'd4,
    REG_TURN_LIMIT = 3'd5
  } reg_idx_t;

  // Duty is the speed magnitude, saturated to the duty range.
  function automatic logic [DutyW-1:0] duty_of(input logic signed [SpeedW-1:0] speed);
    logic [SpeedW-1:0] mag;
    mag = speed[SpeedW-1] ? SpeedW'(-speed) : SpeedW'(speed);
    return (mag > SpeedW'(DutyMax)) ? DutyMax : mag[DutyW-1:0];
  endfunction

endpackage

/* design/pid_line_follower_drive_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_line_follower_drive_core
// PID steering for a line follower with a differential motor drive.
// ---------------------------------------------------------------------------
// The core takes one raw line position per cycle while the output is not
// stalled and returns one drive result per position. A result is held in
// the stage 1, stage 2 and output registers in turn. It is a three-stage
// pipeline: position scaling, then the error, integral and derivative
// update, then the gain products, turn clamp and motor speeds. A new
// position is taken in every cycle unless the output stalls; the sustained
// rate is one item per clock, limited only by backpressure on the output.
// Write gains and limits only while no item is in flight.
`include "pid_line_follower_drive_core_defines.svh"

module pid_line_follower_drive_core (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_we,
  input  logic [plf_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [plf_pkg::CfgDataW-1:0]    cfg_wdata,

  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [12:0] position_raw, [15:13] zero
  input  logic [plf_pkg::InDataW-1:0]     in_tdata,

  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] left_forward, [8:1] left_duty, [9] right_forward,
  // [17:10] right_duty, [28:18] turn_value, [31:29] zero
  output logic [plf_pkg::OutDataW-1:0]    out_tdata
);

  // Configuration registers
  logic signed [plf_pkg::GainW-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [plf_pkg::BaseW-1:0]        base_speed_r;
  logic signed [plf_pkg::PosW-1:0]  target_pos_r;
  logic [plf_pkg::LimW-1:0]         turn_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= plf_pkg::GainW'(256);
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      base_speed_r <= '0;
      target_pos_r <= '0;
      turn_limit_r <= plf_pkg::LimW'(255);
    end else if (cfg_we) begin
      unique case (plf_pkg::reg_idx_t'(cfg_addr))
        plf_pkg::REG_GAIN_P:     gain_p_r     <= cfg_wdata;
        plf_pkg::REG_GAIN_I:     gain_i_r     <= cfg_wdata;
        plf_pkg::REG_GAIN_D:     gain_d_r     <= cfg_wdata;
        plf_pkg::REG_BASE_SPEED: base_speed_r <= cfg_wdata[plf_pkg::BaseW-1:0];
        plf_pkg::REG_TARGET_POS: target_pos_r <= cfg_wdata[plf_pkg::PosW-1:0];
        plf_pkg::REG_TURN_LIMIT: turn_limit_r <= cfg_wdata[plf_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage advances when the next can take it.
  logic s1_valid_r, s2_valid_r, out_tvalid_r;
  logic s1_ready, s2_ready, s3_ready;
  logic in_fire, s1_fire, s2_fire;

  assign s3_ready  = !out_tvalid_r || out_tready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_fire   = in_tvalid && s1_ready;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign s2_fire   = s2_valid_r && s3_ready;

  // Stage 1: clamp and scale the raw position
  logic [plf_pkg::RawW-1:0]         raw_clamp;
  logic [plf_pkg::ScaleProdW-1:0]   scale_prod;
  logic [plf_pkg::ScaleQW-1:0]      scale_q;
  logic signed [plf_pkg::ErrW-1:0]  pos_wide;
  logic signed [plf_pkg::PosW-1:0]  s1_pos_r;

  assign raw_clamp  = (in_tdata[plf_pkg::RawW-1:0] > plf_pkg::RawFull) ?
                      plf_pkg::RawFull : in_tdata[plf_pkg::RawW-1:0];
  assign scale_prod = plf_pkg::ScaleProdW'(raw_clamp) *
                      plf_pkg::ScaleProdW'(plf_pkg::ScaleMul);
  assign scale_q    = scale_prod[plf_pkg::ScaleShift +: plf_pkg::ScaleQW];
  assign pos_wide   = $signed(plf_pkg::ErrW'(scale_q)) - plf_pkg::PosOffset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos_r <= pos_wide[plf_pkg::PosW-1:0];
    end
  end

  // Stage 2: error, saturating integral and derivative; loop state lives here
  logic signed [plf_pkg::ErrW-1:0]   err;
  logic signed [plf_pkg::SumW:0]     sum_wide;
  logic signed [plf_pkg::SumW-1:0]   sum_nxt;
  logic signed [plf_pkg::ErrW:0]     der_wide;
  logic signed [plf_pkg::SumW-1:0]   error_sum_r;
  logic signed [plf_pkg::ErrW-1:0]   prev_err_r;
  logic signed [plf_pkg::ErrW-1:0]   s2_err_r, s2_der_r;
  logic signed [plf_pkg::SumW-1:0]   s2_sum_r;

  assign err      = plf_pkg::ErrW'(s1_pos_r) - plf_pkg::ErrW'(target_pos_r);
  assign sum_wide = (plf_pkg::SumW+1)'(error_sum_r) + (plf_pkg::SumW+1)'(err);
  assign der_wide = (plf_pkg::ErrW+1)'(err) - (plf_pkg::ErrW+1)'(prev_err_r);

  // Saturate when the two top bits disagree
  always_comb begin
    if (sum_wide[plf_pkg::SumW] != sum_wide[plf_pkg::SumW-1]) begin
      sum_nxt = sum_wide[plf_pkg::SumW] ? plf_pkg::SumMin : plf_pkg::SumMax;
    end else begin
      sum_nxt = sum_wide[plf_pkg::SumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      error_sum_r <= '0;
      prev_err_r  <= '0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        error_sum_r <= sum_nxt;
        prev_err_r  <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_err_r <= err;
      s2_sum_r <= sum_nxt;
      s2_der_r <= der_wide[plf_pkg::ErrW-1:0];
    end
  end

  // Stage 3: PID sum, truncate toward zero, clamp, motor speeds
  localparam int PW   = plf_pkg::GainW + plf_pkg::ErrW;
  localparam int IW   = plf_pkg::GainW + plf_pkg::SumW;
  localparam int AccW = IW + 1;
  localparam int QW   = AccW - 8;

  logic signed [PW-1:0]   p_prod, d_prod;
  logic signed [IW-1:0]   i_prod;
  logic signed [AccW-1:0] acc, acc_adj;
  logic signed [QW-1:0]   acc_q, lim_pos, lim_neg, turn_wide;
  logic signed [plf_pkg::TurnW-1:0]  turn;
  logic signed [plf_pkg::SpeedW-1:0] base_s, turn_s, left_spd, right_spd;

  assign p_prod  = PW'(gain_p_r) * PW'(s2_err_r);
  assign i_prod  = IW'(gain_i_r) * IW'(s2_sum_r);
  assign d_prod  = PW'(gain_d_r) * PW'(s2_der_r);
  assign acc     = AccW'(p_prod) + AccW'(i_prod) + AccW'(d_prod);
  assign acc_adj = acc + (acc[AccW-1] ? AccW'(255) : AccW'(0));
  assign acc_q   = acc_adj[AccW-1:8];
  assign lim_pos = $signed(QW'(turn_limit_r));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (acc_q > lim_pos) begin
      turn_wide = lim_pos;
    end else if (acc_q < lim_neg) begin
      turn_wide = lim_neg;
    end else begin
      turn_wide = acc_q;
    end
  end

  assign turn      = turn_wide[plf_pkg::TurnW-1:0];
  assign base_s    = $signed(plf_pkg::SpeedW'(base_speed_r));
  assign turn_s    = plf_pkg::SpeedW'(turn);
  assign left_spd  = base_s + turn_s;
  assign right_spd = base_s - turn_s;

  logic                             left_fwd_r, right_fwd_r;
  logic [plf_pkg::DutyW-1:0]        left_duty_r, right_duty_r;
  logic signed [plf_pkg::TurnW-1:0] turn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s3_ready) begin
      out_tvalid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      left_fwd_r   <= !left_spd[plf_pkg::SpeedW-1];
      left_duty_r  <= plf_pkg::duty_of(left_spd);
      right_fwd_r  <= !right_spd[plf_pkg::SpeedW-1];
      right_duty_r <= plf_pkg::duty_of(right_spd);
      turn_r       <= turn;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, turn_r, right_duty_r, right_fwd_r, left_duty_r, left_fwd_r};

  logic straight_ok;
  assign straight_ok = left_fwd_r && right_fwd_r && (left_duty_r == right_duty_r);

  // Speeds sum to twice the base speed, so both cannot be reverse
  `PLF_ASSERT(a_one_fwd, out_tvalid_r |-> (left_fwd_r || right_fwd_r), "both motors reverse")
  // No turn means both motors run forward at the same duty
  `PLF_ASSERT(a_straight, out_tvalid_r && (turn_r == '0) |-> straight_ok, "uneven drive")
  // A transfer always lands in the scaling stage
  `PLF_ASSERT(a_in_lands, in_fire |=> s1_valid_r, "accepted position lost")
  // Reset empties the output stage
  `PLF_ASSERT_NORST(a_rst_empty, !rst_n |=> !out_tvalid_r, "output valid after reset")

endmodule
